// ===== hdl/mti_mean_clutter_removal_unit_macros.svh =====
// Assertion macros shared by the clutter removal unit.
// Every macro expects signals named clk and arst_n in the enclosing module.
`ifndef MTI_MEAN_CLUTTER_REMOVAL_UNIT_MACROS_SVH
`define MTI_MEAN_CLUTTER_REMOVAL_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define MCRU_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MCRU_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== hdl/mcru_pkg.sv =====
// Shared types and constants of the clutter removal unit.
// No dependencies; imported by mcru_hist, mcru_mean_div and the top module.
`default_nettype none

package mcru_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int BIN_W     = 8;
	localparam int HIST_W    = 6;
	localparam int OUT_W     = 17;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_WIN_FIRST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_LAST  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIST_LEN  = 2'd2;

	localparam logic [BIN_W-1:0] WIN_FIRST_RST = 8'd0;
	localparam logic [BIN_W-1:0] WIN_LAST_RST  = 8'd63;
	localparam int               HIST_RST      = 32;

	typedef struct packed {
		logic                       op;
		logic [BIN_W-1:0]           bin;
		logic signed [SAMPLE_W-1:0] re;
		logic signed [SAMPLE_W-1:0] im;
		logic                       in_win;
	} mcru_item_t;

	typedef struct packed {
		logic       valid;
		mcru_item_t item;
	} mcru_stage_t;

endpackage

`default_nettype wire

// ===== hdl/mcru_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module mcru_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/mcru_hist.sv =====
// Per-bin history: slot state RAM, sample ring RAM and their read-modify-write.
// Depends on mcru_pkg and mcru_ram.
`default_nettype none

module mcru_hist #(
	parameter int MAX_BINS    = 64,
	parameter int MAX_HISTORY = 32,
	parameter int SLOT_W      = 6,
	parameter int SUM_W       = 21
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic [mcru_pkg::HIST_W-1:0]   h_eff,
	input  mcru_pkg::mcru_stage_t         req,
	input  logic [SLOT_W-1:0]             slot,
	output mcru_pkg::mcru_stage_t         req_s3,
	output logic signed [SUM_W-1:0]       sum_s3 [2],
	output logic                          busy
);

	import mcru_pkg::*;

	localparam int PW      = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
	localparam int CMP_W   = ((PW > HIST_W) ? PW : HIST_W) + 1;
	localparam int SLOT_DW = 1 + PW + 2 * SUM_W;
	localparam int RING_W  = 2 * SAMPLE_W;

	logic [MAX_BINS-1:0] vld_q;

	logic                    v_s1, vld_s1;
	mcru_item_t              item_s1;
	logic [SLOT_W-1:0]       slot_s1;

	logic                    v_s2;
	mcru_item_t              item_s2;
	logic [SLOT_W-1:0]       slot_s2;
	logic [PW-1:0]           pos_s2;
	logic                    wrap_s2;
	logic signed [SUM_W-1:0] sum_s2 [2];

	logic                    v_s3;
	mcru_item_t              item_s3;

	logic [SLOT_DW-1:0]      slot_rd, slot_wd;
	logic [RING_W-1:0]       ring_rd, ring_wd;
	logic                    wrap_rd;
	logic [PW-1:0]           pos_rd;
	logic signed [SUM_W-1:0] sum_rd [2];

	logic signed [SAMPLE_W-1:0] old [2];
	logic signed [SUM_W-1:0]    sum_nx [2];
	logic [CMP_W-1:0]           pos_inc;
	logic                       wrap_now;
	logic [PW-1:0]              pos_nx;
	logic                       we;

	mcru_ram #(.WIDTH(SLOT_DW), .DEPTH(2 ** SLOT_W)) u_slot_ram (
		.clk   (clk),
		.we    (we),
		.waddr (slot_s2),
		.wdata (slot_wd),
		.raddr (slot),
		.rdata (slot_rd)
	);

	mcru_ram #(.WIDTH(RING_W), .DEPTH(2 ** (SLOT_W + PW))) u_ring_ram (
		.clk   (clk),
		.we    (we),
		.waddr ({slot_s2, pos_s2}),
		.wdata (ring_wd),
		.raddr ({slot_s1, pos_rd}),
		.rdata (ring_rd)
	);

	// A slot whose flag is clear has never been written since the last clear and reads as empty.
	assign wrap_rd   = vld_s1 & slot_rd[SLOT_DW-1];
	assign pos_rd    = vld_s1 ? slot_rd[SLOT_DW-2 -: PW] : '0;
	assign sum_rd[0] = vld_s1 ? $signed(slot_rd[2*SUM_W-1 -: SUM_W]) : '0;
	assign sum_rd[1] = vld_s1 ? $signed(slot_rd[SUM_W-1:0]) : '0;

	// Until the ring has wrapped once, the entry being replaced was never written.
	assign old[0] = wrap_s2 ? $signed(ring_rd[RING_W-1 -: SAMPLE_W]) : '0;
	assign old[1] = wrap_s2 ? $signed(ring_rd[SAMPLE_W-1:0]) : '0;

	assign sum_nx[0] = sum_s2[0] + SUM_W'($signed(item_s2.re)) - SUM_W'(old[0]);
	assign sum_nx[1] = sum_s2[1] + SUM_W'($signed(item_s2.im)) - SUM_W'(old[1]);

	assign pos_inc  = CMP_W'(pos_s2) + CMP_W'(1);
	assign wrap_now = pos_inc >= CMP_W'(h_eff);
	assign pos_nx   = wrap_now ? '0 : pos_inc[PW-1:0];

	assign we      = v_s2 && item_s2.in_win;
	assign slot_wd = {wrap_s2 | wrap_now, pos_nx, sum_nx[0], sum_nx[1]};
	assign ring_wd = {item_s2.re, item_s2.im};

	assign busy         = v_s1 || v_s2 || v_s3;
	assign req_s3.valid = v_s3;
	assign req_s3.item  = item_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			vld_q <= '0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (clear) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[slot_s2] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		item_s1   <= req.item;
		slot_s1   <= slot;
		vld_s1    <= req.item.in_win && vld_q[slot];
		item_s2   <= item_s1;
		slot_s2   <= slot_s1;
		pos_s2    <= pos_rd;
		wrap_s2   <= wrap_rd;
		sum_s2[0] <= sum_rd[0];
		sum_s2[1] <= sum_rd[1];
		item_s3   <= item_s2;
		sum_s3[0] <= item_s2.in_win ? sum_nx[0] : '0;
		sum_s3[1] <= item_s2.in_win ? sum_nx[1] : '0;
	end

endmodule

`default_nettype wire

// ===== hdl/mcru_mean_div.sv =====
// Mean subtraction: divides the bin sums by the history length through a
// reciprocal multiply with one correction step. Depends on mcru_pkg and the macro header.
`default_nettype none
`include "mti_mean_clutter_removal_unit_macros.svh"

module mcru_mean_div #(
	parameter int SUM_W = 21
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mcru_pkg::mcru_stage_t           req_s3,
	input  logic signed [SUM_W-1:0]         sum_s3 [2],
	input  logic [mcru_pkg::HIST_W-1:0]     h_eff,
	input  logic [SUM_W:0]                  recip,
	input  logic                            take,
	output mcru_pkg::mcru_stage_t           res,
	output logic signed [mcru_pkg::OUT_W-1:0] filt [2],
	output logic                            busy
);

	import mcru_pkg::*;

	logic       v_s4, v_s5, stall;
	mcru_item_t item_s4, item_s5;

	logic                    neg_s4 [2], neg_s5 [2];
	logic [SUM_W-1:0]        mag_s4 [2], mag_s5 [2];
	logic [SUM_W-1:0]        q0_s4 [2], q0_s5 [2];
	logic [SUM_W+HIST_W-1:0] qh_s5 [2];
	logic [SUM_W-1:0]        rem [2];

	assign stall     = v_s5 && !take;
	assign busy      = v_s4 || stall;
	assign res.valid = v_s5;
	assign res.item  = item_s5;

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic                       neg, corr;
		logic [SUM_W-1:0]           mag, q;
		logic [2*SUM_W:0]           prod;
		logic signed [OUT_W-1:0]    qs, mean, smp;

		assign neg  = sum_s3[l][SUM_W-1];
		assign mag  = neg ? $unsigned(SUM_W'(-sum_s3[l])) : $unsigned(sum_s3[l]);
		assign prod = mag * recip;

		// The estimate is never high and at most one below the true quotient.
		assign rem[l] = mag_s5[l] - qh_s5[l][SUM_W-1:0];
		assign corr   = rem[l] >= SUM_W'(h_eff);
		assign q      = q0_s5[l] + SUM_W'(corr);
		assign qs     = $signed(OUT_W'(q));
		assign mean   = neg_s5[l] ? -qs : qs;
		assign smp    = (l == 0) ? OUT_W'($signed(item_s5.re)) : OUT_W'($signed(item_s5.im));
		assign filt[l] = smp - mean;

		always_ff @(posedge clk) begin
			neg_s4[l] <= neg;
			mag_s4[l] <= mag;
			q0_s4[l]  <= prod[2*SUM_W-1:SUM_W];
			if (!stall) begin
				neg_s5[l] <= neg_s4[l];
				mag_s5[l] <= mag_s4[l];
				q0_s5[l]  <= q0_s4[l];
				qh_s5[l]  <= q0_s4[l] * h_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s4 <= req_s3.valid;
			if (!stall) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		item_s4 <= req_s3.item;
		if (!stall) begin
			item_s5 <= item_s4;
		end
	end

	`MCRU_ASSERT_IMPL(a_rem_bound, v_s5, (rem[0] < SUM_W'({h_eff, 1'b0})) && (rem[1] < SUM_W'({h_eff, 1'b0})), "quotient estimate off by more than one")
	`MCRU_ASSERT_NEXT(a_stall_hold, stall, v_s5 && $stable(item_s5) && $stable(q0_s5[0]), "stalled result changed")
	`MCRU_ASSERT_IMPL(a_single_stage, 1'b1, $onehot0({v_s4, v_s5}), "two requests in the divide pipeline")

endmodule

`default_nettype wire

// ===== hdl/mti_mean_clutter_removal_unit.sv =====
// An accepted request passes through the history stages s1-s3, the divide stages s4-s5 and the
// output register. One request at a time holds the slot/ring read-modify-write and the reciprocal
// divide until it reaches the output register; s5 stalls while that register holds an untaken result.
// Reset (arst_n low) restores the window and history length defaults and marks every bin's
// history empty through per-slot flags; a history_length write does the same at once.
`default_nettype none
`include "mti_mean_clutter_removal_unit_macros.svh"

module mti_mean_clutter_removal_unit #(
	parameter int MAX_BINS    = 64,
	parameter int MAX_HISTORY = 32,
	parameter int RANGE_BINS  = 256
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [mcru_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mcru_pkg::CFG_W-1:0]             cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   opcode,
	input  logic [mcru_pkg::BIN_W-1:0]             range_bin,
	input  logic signed [mcru_pkg::SAMPLE_W-1:0]   sample_real,
	input  logic signed [mcru_pkg::SAMPLE_W-1:0]   sample_imag,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [mcru_pkg::BIN_W-1:0]             result_bin,
	output logic signed [mcru_pkg::OUT_W-1:0]      filtered_real,
	output logic signed [mcru_pkg::OUT_W-1:0]      filtered_imag
);

	import mcru_pkg::*;

	localparam int SLOT_W    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int SUM_W     = SAMPLE_W + $clog2(MAX_HISTORY);
	localparam int RECIP_W   = SUM_W + 1;
	localparam int HE_RST    = (HIST_RST > MAX_HISTORY) ? MAX_HISTORY : HIST_RST;
	localparam int RECIP_RST = (2 ** SUM_W) / HE_RST;

	logic [BIN_W-1:0]   first_q, last_q;
	logic [HIST_W-1:0]  heff_q;
	logic [RECIP_W-1:0] recip_q;

	logic [HIST_W-1:0]  heff_tab  [2 ** HIST_W];
	logic [RECIP_W-1:0] recip_tab [2 ** HIST_W];

	logic [BIN_W:0]     diff;
	logic               in_win;
	logic [SLOT_W-1:0]  slot;
	logic               clear;

	mcru_stage_t             hist_req, req_s3, res;
	logic signed [SUM_W-1:0] sum_s3 [2];
	logic signed [OUT_W-1:0] filt [2];
	logic                    hist_busy, div_busy, take;

	logic                    out_valid_q;
	logic [BIN_W-1:0]        result_bin_q;
	logic signed [OUT_W-1:0] filtered_real_q, filtered_imag_q;

	// Effective history length and floor(2^SUM_W / h) for every value of the register.
	for (genvar g = 0; g < 2 ** HIST_W; g++) begin : g_recip
		localparam int HE = (g < 1) ? 1 : ((g > MAX_HISTORY) ? MAX_HISTORY : g);
		localparam int RV = (2 ** SUM_W) / HE;
		assign heff_tab[g]  = HIST_W'(HE);
		assign recip_tab[g] = RECIP_W'(RV);
	end

	assign clear = cfg_we && (cfg_index == REG_HIST_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= WIN_FIRST_RST;
			last_q  <= WIN_LAST_RST;
			heff_q  <= HIST_W'(HE_RST);
			recip_q <= RECIP_W'(RECIP_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIN_FIRST: first_q <= cfg_data[BIN_W-1:0];
				REG_WIN_LAST:  last_q  <= cfg_data[BIN_W-1:0];
				REG_HIST_LEN: begin
					heff_q  <= heff_tab[cfg_data[HIST_W-1:0]];
					recip_q <= recip_tab[cfg_data[HIST_W-1:0]];
				end
				default: ;
			endcase
		end
	end

	// The slot limit also clips the window to the number of stored bins.
	assign diff   = {1'b0, range_bin} - {1'b0, first_q};
	assign in_win = (32'(range_bin) < RANGE_BINS) && (first_q <= last_q) &&
			(range_bin >= first_q) && (range_bin <= last_q) && (32'(diff) < MAX_BINS);
	assign slot   = diff[SLOT_W-1:0];

	assign in_ready            = !(hist_busy || div_busy);
	assign hist_req.valid      = in_valid && in_ready;
	assign hist_req.item.op    = opcode;
	assign hist_req.item.bin   = range_bin;
	assign hist_req.item.re    = sample_real;
	assign hist_req.item.im    = sample_imag;
	assign hist_req.item.in_win = in_win;

	mcru_hist #(
		.MAX_BINS    (MAX_BINS),
		.MAX_HISTORY (MAX_HISTORY),
		.SLOT_W      (SLOT_W),
		.SUM_W       (SUM_W)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (clear),
		.h_eff  (heff_q),
		.req    (hist_req),
		.slot   (slot),
		.req_s3 (req_s3),
		.sum_s3 (sum_s3),
		.busy   (hist_busy)
	);

	mcru_mean_div #(.SUM_W(SUM_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req_s3 (req_s3),
		.sum_s3 (sum_s3),
		.h_eff  (heff_q),
		.recip  (recip_q),
		.take   (take),
		.res    (res),
		.filt   (filt),
		.busy   (div_busy)
	);

	// A record-only request leaves the pipeline without touching the output register.
	assign take = res.valid && (!res.item.op || !out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && res.item.op) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res.item.op) begin
			result_bin_q    <= res.item.bin;
			filtered_real_q <= filt[0];
			filtered_imag_q <= filt[1];
		end
	end

	assign out_valid     = out_valid_q;
	assign result_bin    = result_bin_q;
	assign filtered_real = filtered_real_q;
	assign filtered_imag = filtered_imag_q;

	`MCRU_ASSERT_IMPL(a_one_in_flight, hist_busy, !div_busy, "history and divide stages busy together")
	`MCRU_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, hist_busy, "accepted request did not enter the history stages")
	`MCRU_ASSERT_IMPL(a_pass_through, res.valid && !res.item.in_win, (filt[0] == OUT_W'($signed(res.item.re))) && (filt[1] == OUT_W'($signed(res.item.im))), "bin outside the window was altered")

endmodule

`default_nettype wire
